FILE: src/tbc_pkg.sv
// Shared codes, entry layout and controller/datapath link types for the block cache.
`timescale 1ns / 1ps
`default_nettype none
package tbc_pkg;

  localparam int DEPTH_DEFAULT = 64;

  // Operation codes carried in func.
  localparam logic [2:0] FN_LOOKUP    = 3'd0;
  localparam logic [2:0] FN_INSERT    = 3'd1;
  localparam logic [2:0] FN_INV_SPACE = 3'd2;
  localparam logic [2:0] FN_INV_RANGE = 3'd3;
  localparam logic [2:0] FN_INV_ALL   = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_INVAL = 2'd2;
  localparam logic [1:0] ST_STALE = 2'd3;

  localparam int IN_TDATA_W  = 296;
  localparam int OUT_TDATA_W = 216;

  // One stored translated block.
  typedef struct packed {
    logic [15:0] space;
    logic [63:0] start_pc;
    logic [63:0] end_pc;
    logic [63:0] generation;
    logic [31:0] instr;
    logic [31:0] handle;
    logic [15:0] words;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic decide;
    logic rd;
    logic cmp;
    logic fin;
    logic load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic matched;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: src/translated_block_cache_top.sv
// Top level of the translated block cache: controller, datapath and checks.
`timescale 1ns / 1ps
`default_nettype none
// A fully associative cache of translated code blocks keyed by space, start pc and
// generation, with oldest-first eviction when full. One operation is handled at a time.
// The entry memory has one read port, so the scan reads one entry and then compares it
// before it reads the next (a lookup or insert stops at the first match; invalidations
// walk all entries and compact the survivors in place). Invalidate all, rejected inserts,
// unknown operations, range invalidations that are empty or in space 0 and lookups in
// space 0 skip the scan. A finished result waits in the output register while the next
// operation is accepted; the next result cannot be loaded until that register has been
// taken.
module translated_block_cache_top #(
  parameter int DEPTH = tbc_pkg::DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // func, space_id, start_pc, end_pc, generation, instr_count, program_handle,
  // code_words, zero pad
  input  wire logic [tbc_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // status, hit, found_handle, found_end_pc, found_instr_count,
  // found_code_words, gen_now, zero pad
  output logic [tbc_pkg::OUT_TDATA_W-1:0]        m_tdata
);

  tbc_pkg::cmd_t cmd;
  tbc_pkg::sts_t sts;

  tbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  tbc_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // A returned entry always comes with an ok status.
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[1:0] == tbc_pkg::ST_OK)
    else $error("hit reported with non-ok status");

  // Without a hit the found fields are zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[146:3] == '0)
    else $error("found fields not zero on miss");

  // Only one operation is in flight at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transfer accepted while busy");

endmodule
`default_nettype wire

FILE: src/tbc_ctrl.sv
// Controller state machine that sequences decode, scan, commit and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module tbc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  output tbc_pkg::cmd_t      cmd,
  input  wire tbc_pkg::sts_t sts
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_RD     = 3'd2;
  localparam logic [2:0] S_CMP    = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.capture = s_tvalid && (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = sts.need_scan ? S_RD : S_FIN;
      end
      S_RD: begin
        if (sts.scan_done) begin
          state_next = S_FIN;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = sts.matched ? S_FIN : S_RD;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule
`default_nettype wire

FILE: src/tbc_datapath.sv
// Datapath: entry memory kept in insertion order, scan pointers, generation and result register.
`timescale 1ns / 1ps
`default_nettype none
module tbc_datapath #(
  parameter int DEPTH = tbc_pkg::DEPTH_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire tbc_pkg::cmd_t                       cmd,
  output tbc_pkg::sts_t                            sts,
  input  wire logic [tbc_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [tbc_pkg::OUT_TDATA_W-1:0]          m_tdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  // Entries live at head .. head+count-1 (circular) from oldest to newest.
  tbc_pkg::entry_t mem [DEPTH];
  tbc_pkg::entry_t rd_data;

  logic [AW-1:0] head, rptr, wptr, tail;
  logic [CW-1:0] count, idx, kept;
  logic [63:0]   code_gen;

  // Captured item.
  logic [2:0]  it_func;
  logic [15:0] it_space;
  logic [63:0] it_start, it_end, it_gen;
  logic [31:0] it_instr, it_handle;
  logic [15:0] it_words;

  logic mode_find, mode_purge, mode_ins;

  // Result being built.
  logic [1:0]  res_status;
  logic        res_hit;
  logic [31:0] res_handle, res_instr;
  logic [63:0] res_end;
  logic [15:0] res_words;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  // Decode of the captured item.
  logic is_look, is_ins, is_isp, is_rng, is_all, bad_ins, rng_ok, ins_ok;
  assign is_look = (it_func == tbc_pkg::FN_LOOKUP);
  assign is_ins  = (it_func == tbc_pkg::FN_INSERT);
  assign is_isp  = (it_func == tbc_pkg::FN_INV_SPACE);
  assign is_rng  = (it_func == tbc_pkg::FN_INV_RANGE);
  assign is_all  = (it_func == tbc_pkg::FN_INV_ALL);
  assign bad_ins = (it_space == '0) || (it_handle == '0) || (it_words == '0) ||
                   (it_instr == '0) || (it_end < it_start);
  assign ins_ok  = is_ins && !bad_ins && (it_gen == code_gen);
  assign rng_ok  = is_rng && (it_space != '0) && (it_end > it_start);

  // Entry compares for the scan.
  logic find_match, drop;
  assign find_match = (rd_data.space == it_space) && (rd_data.start_pc == it_start) &&
                      (rd_data.generation == it_gen);
  assign drop = (rd_data.space == it_space) &&
                (is_isp || !((rd_data.end_pc <= it_start) || (rd_data.start_pc >= it_end)));

  // Write slot for a new entry; when full this lands on the head, which is evicted.
  logic [SW-1:0] tail_sum;
  assign tail_sum = SW'(head) + SW'(count);
  assign tail = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

  tbc_pkg::entry_t new_entry;
  assign new_entry = '{space: it_space, start_pc: it_start, end_pc: it_end,
                       generation: it_gen, instr: it_instr, handle: it_handle,
                       words: it_words};

  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  tbc_pkg::entry_t mem_wd;
  assign mem_we = (cmd.cmp && mode_purge && !drop) || (cmd.fin && mode_ins && !res_hit);
  assign mem_wa = cmd.fin ? tail : wptr;
  assign mem_wd = cmd.fin ? new_entry : rd_data;

  assign sts.need_scan = (is_look && (it_space != '0)) || ins_ok || is_isp || rng_ok;
  assign sts.scan_done = (idx == count);
  assign sts.matched   = mode_find && find_match;
  assign sts.out_free  = !m_tvalid || m_tready;

  // Entry memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.rd) rd_data <= mem[rptr];
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_func   <= s_tdata[2:0];
      it_space  <= s_tdata[18:3];
      it_start  <= s_tdata[82:19];
      it_end    <= s_tdata[146:83];
      it_gen    <= s_tdata[210:147];
      it_instr  <= s_tdata[242:211];
      it_handle <= s_tdata[274:243];
      it_words  <= s_tdata[290:275];
    end
  end

  // Control state: queue pointers, generation, scan progress.
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      count      <= '0;
      code_gen   <= 64'd1;
      idx        <= '0;
      kept       <= '0;
      rptr       <= '0;
      wptr       <= '0;
      mode_find  <= 1'b0;
      mode_purge <= 1'b0;
      mode_ins   <= 1'b0;
      res_hit    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.decide) begin
        idx        <= '0;
        kept       <= '0;
        rptr       <= head;
        wptr       <= head;
        res_hit    <= 1'b0;
        mode_find  <= sts.need_scan && (is_look || is_ins);
        mode_ins   <= ins_ok;
        mode_purge <= is_isp || rng_ok;
        if (is_isp || rng_ok || is_all) code_gen <= code_gen + 64'd1;
        if (is_all) count <= '0;
      end
      if (cmd.cmp) begin
        idx  <= idx + CW'(1);
        rptr <= ptr_inc(rptr);
        if (mode_find && find_match) res_hit <= 1'b1;
        if (mode_purge && !drop) begin
          wptr <= ptr_inc(wptr);
          kept <= kept + CW'(1);
        end
      end
      if (cmd.fin) begin
        if (mode_purge) count <= kept;
        if (mode_ins && !res_hit) begin
          res_hit <= 1'b1;
          if (count == CW'(DEPTH)) head  <= ptr_inc(head);
          else                     count <= count + CW'(1);
        end
      end
      if (cmd.load)          m_tvalid <= 1'b1;
      else if (m_tready)     m_tvalid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      res_handle <= '0;
      res_end    <= '0;
      res_instr  <= '0;
      res_words  <= '0;
      if (is_look)                res_status <= tbc_pkg::ST_MISS;
      else if (is_ins && bad_ins) res_status <= tbc_pkg::ST_INVAL;
      else if (is_ins && !ins_ok) res_status <= tbc_pkg::ST_STALE;
      else if (is_ins || is_isp || is_rng || is_all) res_status <= tbc_pkg::ST_OK;
      else                        res_status <= tbc_pkg::ST_INVAL;
    end
    if (cmd.cmp && mode_find && find_match) begin
      res_status <= tbc_pkg::ST_OK;
      res_handle <= rd_data.handle;
      res_end    <= rd_data.end_pc;
      res_instr  <= rd_data.instr;
      res_words  <= rd_data.words;
    end
    if (cmd.fin && mode_ins && !res_hit) begin
      res_handle <= it_handle;
      res_end    <= it_end;
      res_instr  <= it_instr;
      res_words  <= it_words;
    end
    if (cmd.load) begin
      m_tdata <= {5'd0, code_gen, res_words, res_instr, res_end, res_handle,
                  res_hit, res_status};
    end
  end

endmodule
`default_nettype wire

FILE: verif/tb_translated_block_cache_top.sv
// Self-checking testbench for the translated block cache top level.
`timescale 1ns / 1ps
`default_nettype none

// Holds the expected cache results and compares each returned transfer against the oldest one.
class cache_scoreboard;
  // Predicted cache contents, kept in step with the design.
  bit          valid [64];
  logic [15:0] space [64];
  logic [63:0] start [64];
  logic [63:0] endpc [64];
  logic [63:0] gen [64];
  logic [31:0] instr [64];
  logic [31:0] handle [64];
  logic [15:0] words [64];
  int unsigned age [64];
  int unsigned count;
  logic [63:0] cur_gen;
  logic [215:0] pending [$];
  int errors;

  function new();
    foreach (valid[k]) valid[k] = 0;
    count = 0;
    cur_gen = 64'd1;
    errors = 0;
  endfunction

  function void drop(int i);
    int unsigned r;
    r = age[i];
    valid[i] = 0;
    foreach (valid[k]) if (valid[k] && age[k] > r) age[k]--;
    if (count > 0) count--;
  endfunction

  function int find(logic [15:0] sp, logic [63:0] pc, logic [63:0] g);
    foreach (valid[k])
      if (valid[k] && space[k] == sp && start[k] == pc && gen[k] == g) return k;
    return -1;
  endfunction

  // Works out the result of one accepted command and queues it.
  function void note_command(logic [295:0] d);
    logic [2:0] fn;
    logic [15:0] sp, wrd;
    logic [63:0] spc, epc, g;
    logic [31:0] ic, hd;
    logic [1:0] st;
    int i, k;
    fn = d[2:0]; sp = d[18:3]; spc = d[82:19]; epc = d[146:83];
    g = d[210:147]; ic = d[242:211]; hd = d[274:243]; wrd = d[290:275];
    st = tbc_pkg::ST_OK;
    i = -1;
    case (fn)
      tbc_pkg::FN_LOOKUP: begin
        if (sp != 0) i = find(sp, spc, g);
        if (i < 0) st = tbc_pkg::ST_MISS;
      end
      tbc_pkg::FN_INSERT: begin
        if (sp == 0 || hd == 0 || wrd == 0 || ic == 0 || epc < spc) begin
          st = tbc_pkg::ST_INVAL;
        end else if (g != cur_gen) begin
          st = tbc_pkg::ST_STALE;
        end else begin
          i = find(sp, spc, g);
          if (i < 0) begin
            // A full cache gives up its oldest block first.
            if (count >= 64)
              for (k = 0; k < 64; k++)
                if (valid[k] && age[k] == 0) begin
                  drop(k);
                  break;
                end
            for (k = 0; k < 64; k++) if (!valid[k]) break;
            if (k < 64) begin
              i = k;
              valid[i] = 1; space[i] = sp; start[i] = spc; endpc[i] = epc;
              gen[i] = g; instr[i] = ic; handle[i] = hd; words[i] = wrd;
              age[i] = count;
              count++;
            end
          end
        end
      end
      tbc_pkg::FN_INV_SPACE: begin
        cur_gen++;
        for (k = 0; k < 64; k++) if (valid[k] && space[k] == sp) drop(k);
      end
      tbc_pkg::FN_INV_RANGE: begin
        if (sp != 0 && epc > spc) begin
          cur_gen++;
          for (k = 0; k < 64; k++)
            if (valid[k] && space[k] == sp && !(endpc[k] <= spc || start[k] >= epc))
              drop(k);
        end
      end
      tbc_pkg::FN_INV_ALL: begin
        cur_gen++;
        foreach (valid[k]) valid[k] = 0;
        count = 0;
      end
      default: st = tbc_pkg::ST_INVAL;
    endcase
    if (i >= 0)
      pending.push_back({cur_gen, words[i], instr[i], endpc[i], handle[i], 1'b1, st});
    else
      pending.push_back({cur_gen, 16'd0, 32'd0, 64'd0, 32'd0, 1'b0, st});
  endfunction

  // Compares one returned result field by field with the oldest expectation.
  function void check_result(logic [215:0] got);
    logic [215:0] exp;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (got[1:0] != exp[1:0])
      $display("%0t: status exp %0d got %0d", $time, exp[1:0], got[1:0]);
    if (got[2] != exp[2])
      $display("%0t: hit exp %0d got %0d", $time, exp[2], got[2]);
    if (got[34:3] != exp[34:3])
      $display("%0t: handle exp %h got %h", $time, exp[34:3], got[34:3]);
    if (got[98:35] != exp[98:35])
      $display("%0t: end pc exp %h got %h", $time, exp[98:35], got[98:35]);
    if (got[130:99] != exp[130:99])
      $display("%0t: instr count exp %h got %h", $time, exp[130:99], got[130:99]);
    if (got[146:131] != exp[146:131])
      $display("%0t: words exp %h got %h", $time, exp[146:131], got[146:131]);
    if (got[210:147] != exp[210:147])
      $display("%0t: generation exp %h got %h", $time, exp[210:147], got[210:147]);
    if (got[210:0] != exp[210:0]) errors++;
  endfunction
endclass

module tb_translated_block_cache_top;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [tbc_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [tbc_pkg::OUT_TDATA_W-1:0] m_tdata;

  cache_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;
  longint unsigned cycle = 0;
  logic [63:0] addr_pool [8];
  logic [15:0] space_pool [4];

  translated_block_cache_top dut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 2500000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when asked.
  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_result(m_tdata);
    if (rst || hold_off) m_tready <= 0;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Sends one command and waits for its transfer.
  task automatic send(logic [2:0] fn, logic [15:0] sp, logic [63:0] spc, logic [63:0] epc,
                      logic [63:0] g, logic [31:0] ic, logic [31:0] hd, logic [15:0] wrd);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    s_tvalid <= 1;
    s_tdata <= {5'd0, wrd, hd, ic, g, epc, spc, sp, fn};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_command(s_tdata);
    s_tvalid <= 0;
    // The block is busy with the command after a transfer and not ready, so this gap costs nothing.
    @(posedge clk);
  endtask

  // Random command, mostly well-formed inserts and lookups over a small key set.
  task automatic random_command();
    int r;
    logic [63:0] a, b, g;
    logic [15:0] sp;
    r = $urandom_range(99);
    a = addr_pool[$urandom_range(7)];
    b = a + 64'($urandom_range(64));
    sp = space_pool[$urandom_range(3)];
    g = ($urandom_range(9) == 0) ? sb.cur_gen - 64'($urandom_range(2)) : sb.cur_gen;
    if (r < 45)
      send(tbc_pkg::FN_INSERT, sp, a, b, g, $urandom | 1, $urandom | 1, 16'($urandom | 1));
    else if (r < 80)
      send(tbc_pkg::FN_LOOKUP, sp, a, 0, g, 0, 0, 0);
    else if (r < 84)
      send(tbc_pkg::FN_INV_SPACE, sp, 0, 0, 0, 0, 0, 0);
    else if (r < 88)
      send(tbc_pkg::FN_INV_RANGE, sp, a, b, 0, 0, 0, 0);
    else if (r < 89)
      send(tbc_pkg::FN_INV_ALL, 0, 0, 0, 0, 0, 0, 0);
    else if (r < 94)
      send(tbc_pkg::FN_INSERT, 16'($urandom), rand64(), rand64(), g, $urandom_range(1),
           $urandom, 16'($urandom_range(1)));
    else
      send(3'($urandom_range(7)), 16'($urandom), rand64(), rand64(), rand64(), $urandom,
           $urandom, 16'($urandom));
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    sb = new();
    foreach (addr_pool[k]) addr_pool[k] = rand64();
    addr_pool[0] = 64'd0;
    addr_pool[1] = '1 - 64;
    foreach (space_pool[k]) space_pool[k] = 16'($urandom_range(1, 65535));
    space_pool[0] = 16'hFFFF;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, every operation and the corner cases.
    send(tbc_pkg::FN_INSERT, 16'hFFFF, '1, '1, 1, '1, '1, '1);
    send(tbc_pkg::FN_LOOKUP, 16'hFFFF, '1, 0, 1, 0, 0, 0);
    send(tbc_pkg::FN_LOOKUP, 0, '1, 0, 1, 0, 0, 0);
    send(tbc_pkg::FN_LOOKUP, 1, 0, 0, 0, 0, 0, 0);
    send(tbc_pkg::FN_INSERT, 16'hFFFF, '1, '1, 1, 5, 6, 7);
    send(tbc_pkg::FN_INSERT, 0, 0, 0, 1, 1, 1, 1);
    send(tbc_pkg::FN_INSERT, 1, 0, 0, 1, 1, 0, 1);
    send(tbc_pkg::FN_INSERT, 1, 0, 0, 1, 1, 1, 0);
    send(tbc_pkg::FN_INSERT, 1, 0, 0, 1, 0, 1, 1);
    send(tbc_pkg::FN_INSERT, 1, 10, 9, 1, 1, 1, 1);
    send(tbc_pkg::FN_INSERT, 1, 0, 0, 2, 1, 1, 1);
    send(tbc_pkg::FN_INSERT, 1, 16, 32, 1, 1, 1, 1);
    send(tbc_pkg::FN_INV_RANGE, 1, 32, 40, 0, 0, 0, 0);
    send(tbc_pkg::FN_INV_RANGE, 1, 20, 20, 0, 0, 0, 0);
    send(tbc_pkg::FN_INV_RANGE, 0, 0, 40, 0, 0, 0, 0);
    send(tbc_pkg::FN_LOOKUP, 16'hFFFF, '1, 0, 1, 0, 0, 0);
    send(tbc_pkg::FN_INV_RANGE, 1, 31, 32, 0, 0, 0, 0);
    send(tbc_pkg::FN_LOOKUP, 1, 16, 0, 1, 0, 0, 0);
    send(tbc_pkg::FN_INV_SPACE, 0, 0, 0, 0, 0, 0, 0);
    send(tbc_pkg::FN_INV_SPACE, 16'hFFFF, 0, 0, 0, 0, 0, 0);
    send(tbc_pkg::FN_INV_ALL, 0, 0, 0, 0, 0, 0, 0);
    send(3'd5, 0, 0, 0, 0, 0, 0, 0);
    send(3'd7, '1, '1, '1, '1, '1, '1, '1);

    // Fill past capacity so eviction happens, then a long receiver hold-off.
    for (n = 0; n < 70; n++)
      send(tbc_pkg::FN_INSERT, 3, 64'(n), 64'(n + 1), sb.cur_gen, 1, 32'(n + 1), 1);
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      for (n = 0; n < 8; n++)
        send(tbc_pkg::FN_LOOKUP, 3, 64'(n + 6), 0, sb.cur_gen, 0, 0, 0);
    join
    drain();

    // Random phases with different idling.
    for (n = 0; n < 1450; n++) begin
      case (n / 100 % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      random_command();
    end

    drain();
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
